### rtl/mcc_pkg.sv
// Package: shared types, constants and helpers of the 14-bit controller pair combiner.
package mcc_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int BASE_COUNT   = 32;
   localparam int STORE_DEPTH  = NUM_CHANNELS * BASE_COUNT;
   localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CHAN_W       = 4;
   localparam int BASE_W       = 5;
   localparam int PART_W       = 7;
   localparam int CTRL_W       = 7;
   localparam int VALUE_W      = 2 * PART_W;

   localparam logic [CTRL_W-1:0] CTRL_HIGH_LAST = CTRL_W'(31);
   localparam logic [CTRL_W-1:0] CTRL_LOW_LAST  = CTRL_W'(63);

   typedef struct packed {
      logic              high_present;
      logic              low_present;
      logic [PART_W-1:0] high_part;
      logic [PART_W-1:0] low_part;
   } mcc_entry_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [BASE_W-1:0] base;
      logic              is_high;
      logic [PART_W-1:0] data;
   } mcc_event_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      mcc_entry_type     data;
   } mcc_write_type;

   function automatic logic [ADDR_W-1:0] slot_of(input logic [CHAN_W-1:0] channel,
                                                 input logic [BASE_W-1:0] base);
      logic [CHAN_W+BASE_W-1:0] full;
      full = {channel, base};
      return full[ADDR_W-1:0];
   endfunction

endpackage

### rtl/midi_14bit_cc_pair_combiner.sv
// Top level: MIDI 14-bit control change pair combiner.
//
//   channel  direction  transfer when        payload
//   req      in         start && !busy       is_control_change, channel,
//                                            controller_number, data_value
//   rsp      out        rsp_valid            out_channel, base_controller,
//                                            combined_value
//
// One event per cycle while busy is low. A completed pair transfers on rsp from
// registers: the store read and the event register first, then the merged result.
// The last write is forwarded, so back-to-back events on one slot pair right.
// After reset busy stays high while all 512 store entries are swept clear.
// The receiver cannot stall; rsp_valid is a one-cycle strobe.
module midi_14bit_cc_pair_combiner
   import mcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_is_control_change,
   input  logic [CHAN_W-1:0]  req_channel,
   input  logic [CTRL_W-1:0]  req_controller_number,
   input  logic [PART_W-1:0]  req_data_value,
   output logic               rsp_valid,
   output logic [CHAN_W-1:0]  rsp_out_channel,
   output logic [BASE_W-1:0]  rsp_base_controller,
   output logic [VALUE_W-1:0] rsp_combined_value
);

   logic          clearing;
   logic          accept;
   logic          ev_valid;
   mcc_event_type ev;
   mcc_entry_type rd_data;
   mcc_write_type wr;

   assign busy   = clearing;
   assign accept = start && !clearing;

   always_comb begin
      ev.channel = req_channel;
      ev.is_high = (req_controller_number <= CTRL_HIGH_LAST);
      ev.base    = req_controller_number[BASE_W-1:0];
      ev.data    = req_data_value;
      ev_valid   = accept && req_is_control_change
                   && (req_controller_number <= CTRL_LOW_LAST)
                   && ({1'b0, req_channel} < (CHAN_W + 1)'(NUM_CHANNELS));
   end

   mcc_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (ev_valid),
      .rd_addr  (slot_of(ev.channel, ev.base)),
      .rd_data  (rd_data),
      .wr       (wr),
      .clearing (clearing)
   );

   mcc_pair u_pair (
      .clock       (clock),
      .reset       (reset),
      .ev_valid    (ev_valid),
      .ev          (ev),
      .rd_data     (rd_data),
      .wr          (wr),
      .rsp_valid   (rsp_valid),
      .rsp_channel (rsp_out_channel),
      .rsp_base    (rsp_base_controller),
      .rsp_value   (rsp_combined_value)
   );

endmodule

### rtl/mcc_store.sv
// Pair store: entry memory with registered read and a clearing sweep after reset.
module mcc_store
   import mcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output mcc_entry_type      rd_data,
   input  mcc_write_type      wr,
   output logic               clearing
);

   mcc_entry_type     mem [STORE_DEPTH];
   mcc_entry_type     rd_data_ff;
   logic              clear_ff;
   logic              clear_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              clr_last;

   assign clr_last = (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1));

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_last) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clear_ff;

endmodule

### rtl/mcc_pair.sv
// Pairing stage: merge an event into its entry, forward the last write, register the result.
module mcc_pair
   import mcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               ev_valid,
   input  mcc_event_type      ev,
   input  mcc_entry_type      rd_data,
   output mcc_write_type      wr,
   output logic               rsp_valid,
   output logic [CHAN_W-1:0]  rsp_channel,
   output logic [BASE_W-1:0]  rsp_base,
   output logic [VALUE_W-1:0] rsp_value
);

   logic               ev_valid_ff;
   mcc_event_type      ev_ff;
   logic               fw_valid_ff;
   logic [ADDR_W-1:0]  fw_addr_ff;
   mcc_entry_type      fw_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [CHAN_W-1:0]  rsp_channel_ff;
   logic [BASE_W-1:0]  rsp_base_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [VALUE_W-1:0] rsp_value_in;
   logic [ADDR_W-1:0]  addr;
   mcc_entry_type      cur;
   mcc_entry_type      upd;
   mcc_entry_type      nxt;

   assign addr = slot_of(ev_ff.channel, ev_ff.base);

   always_comb begin
      cur = (fw_valid_ff && (fw_addr_ff == addr)) ? fw_data_ff : rd_data;
      upd = cur;
      if (ev_ff.is_high) begin
         upd.high_part    = ev_ff.data;
         upd.high_present = 1'b1;
      end else begin
         upd.low_part    = ev_ff.data;
         upd.low_present = 1'b1;
      end
      rsp_valid_in = ev_valid_ff && upd.high_present && upd.low_present;
      rsp_value_in = {upd.high_part, upd.low_part};
      nxt = upd;
      if (upd.high_present && upd.low_present) begin
         nxt.high_present = 1'b0;
         nxt.low_present  = 1'b0;
      end
   end

   assign wr = '{en: ev_valid_ff, addr: addr, data: nxt};

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff  <= ev_valid;
         fw_valid_ff  <= ev_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff          <= ev;
      fw_addr_ff     <= addr;
      fw_data_ff     <= nxt;
      rsp_channel_ff <= ev_ff.channel;
      rsp_base_ff    <= ev_ff.base;
      rsp_value_ff   <= rsp_value_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_base    = rsp_base_ff;
   assign rsp_value   = rsp_value_ff;

endmodule
